// ===== rtl/lrpfb_pkg.sv =====
// shared types and constants for the packed framebuffer line rasterizer
// no dependencies
`timescale 1ns / 1ps

package lrpfb_pkg;

  // screen geometry, framebuffer sits at byte offset zero
  localparam int FB_COLUMNS = 640;

  localparam int COORD_W = 10;
  localparam int ROW_W   = 9;
  localparam int PEN_W   = 4;
  localparam int ERR_W   = 11;
  localparam int IDX_W   = 20;
  localparam int ADDR_W  = 18;

  // input word action codes
  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

  // stepper state for the line in progress
  typedef struct packed {
    logic                      active;
    logic                      steep;
    logic [COORD_W-1:0]        major_pos;
    logic [COORD_W-1:0]        major_end;
    logic [COORD_W-1:0]        minor_pos;
    logic                      minor_dir_down;
    logic [COORD_W-1:0]        delta_major;
    logic [COORD_W-1:0]        delta_minor;
    logic signed [ERR_W-1:0]   error_term;
    logic [PEN_W-1:0]          line_pen;
  } line_state_t;

  // one emitted pixel write
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [ROW_W-1:0]   pixel_y;
    logic [PEN_W-1:0]   pixel_pen;
    logic [ADDR_W-1:0]  byte_address;
    logic               high_nibble;
    logic               last;
  } pixel_t;

endpackage

// ===== rtl/line_rasterizer_packed_fb.sv =====
// top level of the packed framebuffer line rasterizer
// depends on lrpfb_pkg, lrpfb_setup, lrpfb_step
`timescale 1ns / 1ps

// usage
//   input channel (in_valid / in_ready) takes one word per cycle when ready:
//   a start word (in_action low) loads both endpoints and the pen and gives no
//   result; an advance word (in_action high) gives the next pixel of the
//   active line; an advance while no line is active is taken and dropped
//   result channel (out_valid / out_ready) carries one pixel write per word:
//   coordinates, pen nibble, byte address, nibble select and a last flag
//   a pixel is registered in the cycle after its advance word is taken
//   one word per cycle while ready, set by the single output register; the
//   stepper state updates in the same cycle the word is taken
//   a new word is taken while the held result is being read out, so a
//   stalled receiver only blocks the input while the output register is full
//   reset clears the line state (no line active) and empties the output
//   a start word during an active line drops the old line

module line_rasterizer_packed_fb (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [lrpfb_pkg::COORD_W-1:0] in_x_start,
  input  logic [lrpfb_pkg::ROW_W-1:0]   in_y_start,
  input  logic [lrpfb_pkg::COORD_W-1:0] in_x_end,
  input  logic [lrpfb_pkg::ROW_W-1:0]   in_y_end,
  input  logic [lrpfb_pkg::PEN_W-1:0]   in_pen,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrpfb_pkg::COORD_W-1:0] out_pixel_x,
  output logic [lrpfb_pkg::ROW_W-1:0]   out_pixel_y,
  output logic [lrpfb_pkg::PEN_W-1:0]   out_pixel_pen,
  output logic [lrpfb_pkg::ADDR_W-1:0]  out_byte_address,
  output logic                          out_high_nibble,
  output logic                          out_last
);

  lrpfb_pkg::line_state_t state_r, state_nxt;
  lrpfb_pkg::line_state_t load_state, step_state;
  lrpfb_pkg::pixel_t      step_pixel;
  lrpfb_pkg::pixel_t      pix_r, pix_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   in_accept;
  logic                   is_start;
  logic                   emit;

  // endpoint ordering for a start word
  lrpfb_setup u_setup (
    .x_start    (in_x_start),
    .y_start    (in_y_start),
    .x_end      (in_x_end),
    .y_end      (in_y_end),
    .pen        (in_pen),
    .load_state (load_state)
  );

  // current pixel and next stepper state
  lrpfb_step u_step (
    .cur_state  (state_r),
    .next_state (step_state),
    .pixel      (step_pixel)
  );

  // output register frees up when its word leaves this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign is_start  = in_action == lrpfb_pkg::ACT_START;
  // advance on an active line is the only word that produces a pixel
  assign emit      = in_accept && !is_start && state_r.active;

  always_comb begin
    state_nxt = state_r;
    pix_nxt   = pix_r;
    if (in_accept && is_start) begin
      state_nxt = load_state;
    end else if (emit) begin
      state_nxt = step_state;
      pix_nxt   = step_pixel;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = pix_r.pixel_x;
  assign out_pixel_y      = pix_r.pixel_y;
  assign out_pixel_pen    = pix_r.pixel_pen;
  assign out_byte_address = pix_r.byte_address;
  assign out_high_nibble  = pix_r.high_nibble;
  assign out_last         = pix_r.last;

endmodule

// ===== rtl/lrpfb_setup.sv =====
// line setup: orders the endpoints along the major axis and derives deltas
// depends on lrpfb_pkg
`timescale 1ns / 1ps

module lrpfb_setup (
  input  logic [lrpfb_pkg::COORD_W-1:0] x_start,
  input  logic [lrpfb_pkg::ROW_W-1:0]   y_start,
  input  logic [lrpfb_pkg::COORD_W-1:0] x_end,
  input  logic [lrpfb_pkg::ROW_W-1:0]   y_end,
  input  logic [lrpfb_pkg::PEN_W-1:0]   pen,
  output lrpfb_pkg::line_state_t        load_state
);

  logic [lrpfb_pkg::COORD_W-1:0] ya, yb, dx, dy;
  logic [lrpfb_pkg::COORD_W-1:0] ma, mb, na, nb;
  logic [lrpfb_pkg::COORD_W-1:0] m_lo, m_hi, n_lo, n_hi;
  logic                          steep;

  always_comb begin
    ya = lrpfb_pkg::COORD_W'(y_start);
    yb = lrpfb_pkg::COORD_W'(y_end);
    dx = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
    dy = (ya > yb) ? (ya - yb) : (yb - ya);
    steep = dy > dx;

    if (steep) begin
      ma = ya; na = x_start; mb = yb; nb = x_end;
    end else begin
      ma = x_start; na = ya; mb = x_end; nb = yb;
    end

    // walk from the smaller major coordinate
    if (ma > mb) begin
      m_lo = mb; m_hi = ma; n_lo = nb; n_hi = na;
    end else begin
      m_lo = ma; m_hi = mb; n_lo = na; n_hi = nb;
    end

    load_state.active         = 1'b1;
    load_state.steep          = steep;
    load_state.major_pos      = m_lo;
    load_state.major_end      = m_hi;
    load_state.minor_pos      = n_lo;
    load_state.minor_dir_down = n_lo > n_hi;
    load_state.delta_major    = m_hi - m_lo;
    load_state.delta_minor    = (n_lo > n_hi) ? (n_lo - n_hi) : (n_hi - n_lo);
    load_state.error_term     = $signed({2'b00, load_state.delta_major[lrpfb_pkg::COORD_W-1:1]});
    load_state.line_pen       = pen;
  end

endmodule

// ===== rtl/lrpfb_step.sv =====
// pixel stepper: emits the current pixel and advances the bresenham state
// depends on lrpfb_pkg
`timescale 1ns / 1ps

module lrpfb_step (
  input  lrpfb_pkg::line_state_t cur_state,
  output lrpfb_pkg::line_state_t next_state,
  output lrpfb_pkg::pixel_t      pixel
);

  logic [lrpfb_pkg::COORD_W-1:0]    px, py;
  logic [lrpfb_pkg::IDX_W-1:0]      idx;
  logic                             fin;
  logic signed [lrpfb_pkg::ERR_W-1:0] err_sub;

  always_comb begin
    px  = cur_state.steep ? cur_state.minor_pos : cur_state.major_pos;
    py  = cur_state.steep ? cur_state.major_pos : cur_state.minor_pos;
    // constant multiply, folds into shifts and adds
    idx = lrpfb_pkg::IDX_W'(py) * lrpfb_pkg::IDX_W'(lrpfb_pkg::FB_COLUMNS)
          + lrpfb_pkg::IDX_W'(px);
    fin = cur_state.major_pos == cur_state.major_end;

    pixel.pixel_x      = px;
    pixel.pixel_y      = py[lrpfb_pkg::ROW_W-1:0];
    pixel.pixel_pen    = cur_state.line_pen;
    pixel.byte_address = idx[lrpfb_pkg::ADDR_W:1];
    pixel.high_nibble  = idx[0];
    pixel.last         = fin;

    err_sub = cur_state.error_term - $signed({1'b0, cur_state.delta_minor});

    next_state = cur_state;
    if (fin) begin
      next_state.active = 1'b0;
    end else begin
      next_state.major_pos  = cur_state.major_pos + 1'b1;
      next_state.error_term = err_sub;
      if (err_sub < 0) begin
        next_state.minor_pos  = cur_state.minor_dir_down ?
                                (cur_state.minor_pos - 1'b1) : (cur_state.minor_pos + 1'b1);
        next_state.error_term = err_sub + $signed({1'b0, cur_state.delta_major});
      end
    end
  end

endmodule

// ===== tb/line_rasterizer_packed_fb_tb.sv =====
// self-checking testbench for the packed framebuffer line rasterizer
// depends on lrpfb_pkg and line_rasterizer_packed_fb, nothing else
`timescale 1ns / 1ps

module line_rasterizer_packed_fb_tb;

  // random traffic stops once this many start / productive advance words went in
  localparam int RANDOM_WORDS = 1700;
  // cycles to watch the result port once nothing is expected any more
  localparam int SETTLE_CYCLES = 10;
  // cap on printed mismatch lines, the count keeps going
  localparam int MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst_n;

  logic                          in_valid;
  logic                          in_ready;
  logic                          in_action;
  logic [lrpfb_pkg::COORD_W-1:0] in_x_start;
  logic [lrpfb_pkg::ROW_W-1:0]   in_y_start;
  logic [lrpfb_pkg::COORD_W-1:0] in_x_end;
  logic [lrpfb_pkg::ROW_W-1:0]   in_y_end;
  logic [lrpfb_pkg::PEN_W-1:0]   in_pen;

  logic                          out_valid;
  logic                          out_ready;
  logic [lrpfb_pkg::COORD_W-1:0] out_pixel_x;
  logic [lrpfb_pkg::ROW_W-1:0]   out_pixel_y;
  logic [lrpfb_pkg::PEN_W-1:0]   out_pixel_pen;
  logic [lrpfb_pkg::ADDR_W-1:0]  out_byte_address;
  logic                          out_high_nibble;
  logic                          out_last;

  // shadow copy of the line stepper, 2-state so it powers up cleared
  typedef struct {
    bit                          active;
    bit                          steep;
    bit                          minor_down;
    bit [lrpfb_pkg::COORD_W-1:0] major_pos;
    bit [lrpfb_pkg::COORD_W-1:0] major_end;
    bit [lrpfb_pkg::COORD_W-1:0] minor_pos;
    bit [lrpfb_pkg::COORD_W-1:0] delta_major;
    bit [lrpfb_pkg::COORD_W-1:0] delta_minor;
    int                          err;
    bit [lrpfb_pkg::PEN_W-1:0]   pen;
  } stepper_t;

  stepper_t          tracer;
  lrpfb_pkg::pixel_t pending_pixels[$];

  // knobs for the two idle generators
  bit idle_en  = 1'b1;
  bit stall_en = 1'b1;

  int words_taken   = 0;
  int lines_started = 0;
  int idle_drops    = 0;
  int pixels_seen   = 0;
  int mismatches    = 0;

  int unsigned ready_left = 0;

  line_rasterizer_packed_fb DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_pen          (in_pen),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_pen   (out_pixel_pen),
    .out_byte_address(out_byte_address),
    .out_high_nibble (out_high_nibble),
    .out_last        (out_last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int span_of(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int clip(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // expected behavior for one accepted word: a start loads the stepper,
  // an advance on an active line yields the next pixel write
  task automatic rasterize_word(input bit act, input bit [lrpfb_pkg::COORD_W-1:0] xa,
                                input bit [lrpfb_pkg::ROW_W-1:0] ya,
                                input bit [lrpfb_pkg::COORD_W-1:0] xb,
                                input bit [lrpfb_pkg::ROW_W-1:0] yb,
                                input bit [lrpfb_pkg::PEN_W-1:0] pen);
    int                            ma, mb, na, nb, t;
    bit [lrpfb_pkg::COORD_W-1:0]   px, py;
    logic [lrpfb_pkg::IDX_W-1:0]   idx;
    lrpfb_pkg::pixel_t             pix;
    if (act == lrpfb_pkg::ACT_START) begin
      // major axis is y only when the rise beats the run
      tracer.steep = span_of(ya, yb) > span_of(xa, xb);
      if (tracer.steep) begin
        ma = ya; na = xa; mb = yb; nb = xb;
      end else begin
        ma = xa; na = ya; mb = xb; nb = yb;
      end
      // always walk from the smaller major coordinate
      if (ma > mb) begin
        t = ma; ma = mb; mb = t;
        t = na; na = nb; nb = t;
      end
      tracer.major_pos   = lrpfb_pkg::COORD_W'(ma);
      tracer.major_end   = lrpfb_pkg::COORD_W'(mb);
      tracer.minor_pos   = lrpfb_pkg::COORD_W'(na);
      tracer.minor_down  = na > nb;
      tracer.delta_major = lrpfb_pkg::COORD_W'(mb - ma);
      tracer.delta_minor = lrpfb_pkg::COORD_W'(span_of(na, nb));
      tracer.err         = int'(tracer.delta_major) >>> 1;
      tracer.pen         = pen;
      tracer.active      = 1'b1;
      lines_started++;
      words_taken++;
    end else if (!tracer.active) begin
      idle_drops++;
    end else begin
      px = tracer.steep ? tracer.minor_pos : tracer.major_pos;
      py = tracer.steep ? tracer.major_pos : tracer.minor_pos;
      idx = lrpfb_pkg::IDX_W'(py * lrpfb_pkg::FB_COLUMNS + px);
      pix.pixel_x      = px;
      pix.pixel_y      = py[lrpfb_pkg::ROW_W-1:0];
      pix.pixel_pen    = tracer.pen;
      pix.byte_address = idx[lrpfb_pkg::ADDR_W:1];
      pix.high_nibble  = idx[0];
      pix.last         = tracer.major_pos == tracer.major_end;
      pending_pixels.push_back(pix);
      words_taken++;
      if (pix.last) begin
        tracer.active = 1'b0;
      end else begin
        tracer.major_pos = tracer.major_pos + 1'b1;
        tracer.err = tracer.err - int'(tracer.delta_minor);
        if (tracer.err < 0) begin
          tracer.minor_pos = tracer.minor_down ? tracer.minor_pos - 1'b1
                                               : tracer.minor_pos + 1'b1;
          tracer.err = tracer.err + int'(tracer.delta_major);
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // one monitor at the rising edge: check the pixel leaving, then predict the
  // word entering, so a same-edge push never races the pop
  always @(posedge clk) begin
    lrpfb_pkg::pixel_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: pixel (%0d,%0d) with nothing expected, got addr %0d",
                     $time, out_pixel_x, out_pixel_y, out_byte_address);
        end else begin
          want = pending_pixels.pop_front();
          compare_field("pixel_x", want.pixel_x, out_pixel_x);
          compare_field("pixel_y", want.pixel_y, out_pixel_y);
          compare_field("pixel_pen", want.pixel_pen, out_pixel_pen);
          compare_field("byte_address", want.byte_address, out_byte_address);
          compare_field("high_nibble", want.high_nibble, out_high_nibble);
          compare_field("last", want.last, out_last);
        end
      end
      if (in_valid && in_ready)
        rasterize_word(in_action, in_x_start, in_y_start, in_x_end, in_y_end, in_pen);
    end
  end

  // receiver: alternating runs of ready and stall, or always ready
  always @(negedge clk) begin
    if (!stall_en) begin
      out_ready = 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else begin
      out_ready  = ~out_ready;
      ready_left = out_ready ? $urandom_range(0, 6) : pick_gap();
    end
  end

  // drive one word at the falling edge, hold it until the rising edge takes it
  task automatic send_word(input lrpfb_pkg::action_t act, input int xs, input int ys,
                           input int xe, input int ye, input int pen);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_action  = act;
    in_x_start = lrpfb_pkg::COORD_W'(xs);
    in_y_start = lrpfb_pkg::ROW_W'(ys);
    in_x_end   = lrpfb_pkg::COORD_W'(xe);
    in_y_end   = lrpfb_pkg::ROW_W'(ye);
    in_pen     = lrpfb_pkg::PEN_W'(pen);
    do @(posedge clk); while (!in_ready);
  endtask

  // advance word, the endpoint fields are don't-care so fill them with noise
  task automatic send_advance();
    send_word(lrpfb_pkg::ACT_ADVANCE, $urandom_range(0, 639), $urandom_range(0, 479),
              $urandom_range(0, 639), $urandom_range(0, 479), $urandom_range(0, 15));
  endtask

  // hold the sender off until every predicted pixel has come out
  task automatic wait_all_pixels();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // random line, mostly short, some medium, a few anywhere on screen;
  // returns how many pixels it has
  task automatic send_random_line(output int pixels);
    int xa, ya, xb, yb, reach, r;
    r  = $urandom_range(0, 99);
    xa = $urandom_range(0, 639);
    ya = $urandom_range(0, 479);
    if (r < 5) begin
      xb = $urandom_range(0, 639);
      yb = $urandom_range(0, 479);
    end else begin
      reach = (r < 85) ? 12 : 80;
      xb = clip(xa + $urandom_range(0, 2 * reach) - reach, 639);
      yb = clip(ya + $urandom_range(0, 2 * reach) - reach, 479);
    end
    // flat and upright spans get extra weight
    case ($urandom_range(0, 9))
      0: yb = ya;
      1: xb = xa;
      default: ;
    endcase
    send_word(lrpfb_pkg::ACT_START, xa, ya, xb, yb, $urandom_range(0, 15));
    pixels = ((span_of(xa, xb) > span_of(ya, yb)) ? span_of(xa, xb) : span_of(ya, yb)) + 1;
  endtask

  // advance with no line loaded must be swallowed
  task automatic test_idle_advance();
    send_advance();
  endtask

  // equal endpoints at the origin with pen 0: one pixel, last set, then idle
  task automatic test_single_point();
    send_word(lrpfb_pkg::ACT_START, 0, 0, 0, 0, 0);
    send_advance();
    send_advance();
  endtask

  // flat and upright spans given back to front at the far screen corners
  task automatic test_reversed_spans();
    send_word(lrpfb_pkg::ACT_START, 639, 479, 636, 479, 15);
    repeat (4) send_advance();
    send_word(lrpfb_pkg::ACT_START, 0, 479, 0, 476, 5);
    repeat (4) send_advance();
  endtask

  // shallow line with a falling minor axis, cut off by a steep line
  task automatic test_restart();
    send_word(lrpfb_pkg::ACT_START, 5, 2, 0, 4, 10);
    repeat (2) send_advance();
    send_word(lrpfb_pkg::ACT_START, 2, 3, 1, 0, 3);
    repeat (4) send_advance();
  endtask

  // bulk traffic: whole lines mostly, some cut short (the next start drops
  // them), some with extra advances past the end, stray advances between
  task automatic test_random_lines();
    int pixels, adv, r, line_no;
    line_no = 0;
    while (words_taken < RANDOM_WORDS) begin
      // switch idle style every few lines, including no idling at all
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 3);
        idle_en  = r[0];
        stall_en = r[1];
      end
      if ($urandom_range(0, 19) == 0)
        send_advance();
      send_random_line(pixels);
      r = $urandom_range(0, 99);
      if (r < 12)
        adv = $urandom_range(0, pixels - 1);
      else if (r < 22)
        adv = pixels + $urandom_range(1, 3);
      else
        adv = pixels;
      repeat (adv) send_advance();
      line_no++;
      // sender pauses until the pipe is empty every so often
      if (line_no % 16 == 8)
        wait_all_pixels();
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_action  = lrpfb_pkg::ACT_START;
    in_x_start = '0;
    in_y_start = '0;
    in_x_end   = '0;
    in_y_end   = '0;
    in_pen     = '0;
    out_ready  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_advance();
    test_single_point();
    test_reversed_spans();
    test_restart();
    test_random_lines();

    // drain with the receiver always ready, then watch the port a while
    stall_en = 1'b0;
    wait_all_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("drew %0d lines, checked %0d pixel writes, %0d advances dropped while idle",
             lines_started, pixels_seen, idle_drops);
    $display("%0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lrpfb_pkg.sv
rtl/lrpfb_setup.sv
rtl/lrpfb_step.sv
rtl/line_rasterizer_packed_fb.sv
tb/line_rasterizer_packed_fb_tb.sv
